### design/bpc_pkg.sv
// Shared types, codes and reset values for the button press classifier.
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned IN_TDATA_W = 40;
	localparam int unsigned OUT_TDATA_W = 40;

	localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 32'd20;
	localparam logic [TIME_W-1:0] LONG_PRESS_RESET = 32'd2000;
	localparam logic [TIME_W-1:0] DOUBLE_PRESS_RESET = 32'd400;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_NORMAL = 2'd1,
		KIND_LONG   = 2'd2
	} press_kind_t;

	typedef enum logic [2:0] {
		REG_DEBOUNCE     = 3'd0,
		REG_LONG_PRESS   = 3'd1,
		REG_DOUBLE_PRESS = 3'd2,
		REG_INVERT       = 3'd3,
		REG_PAUSED       = 3'd4
	} reg_index_t;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_START = 1'b1
	} op_t;

	typedef struct packed {
		logic [TIME_W-1:0] debounce_ms;
		logic [TIME_W-1:0] long_press_ms;
		logic [TIME_W-1:0] double_press_ms;
		logic              invert_polarity;
		logic              paused;
	} cfg_t;

	typedef struct packed {
		op_t               op;
		logic              pin_level;
		logic [TIME_W-1:0] now_ms;
	} in_item_t;

	typedef struct packed {
		press_kind_t       press_kind;
		logic [TIME_W-1:0] hold_ms;
		logic              double_press;
		logic              long_press_event;
		logic              release_event;
		logic              press_event;
	} result_t;

endpackage
`default_nettype wire

### design/bpc_regs.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none
module bpc_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [bpc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [bpc_pkg::DATA_W-1:0] pwdata,
	output logic      [bpc_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output bpc_pkg::cfg_t                   cfg
);
	import bpc_pkg::*;

	cfg_t       cfg_q;
	reg_index_t reg_idx;
	logic       wr_en;

	assign reg_idx = reg_index_t'(paddr[ADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite & pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms <= DEBOUNCE_RESET;
			cfg_q.long_press_ms <= LONG_PRESS_RESET;
			cfg_q.double_press_ms <= DOUBLE_PRESS_RESET;
			cfg_q.invert_polarity <= 1'b0;
			cfg_q.paused <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_DEBOUNCE:     cfg_q.debounce_ms <= pwdata;
				REG_LONG_PRESS:   cfg_q.long_press_ms <= pwdata;
				REG_DOUBLE_PRESS: cfg_q.double_press_ms <= pwdata;
				REG_INVERT:       cfg_q.invert_polarity <= pwdata[0];
				REG_PAUSED:       cfg_q.paused <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DEBOUNCE:     prdata = cfg_q.debounce_ms;
			REG_LONG_PRESS:   prdata = cfg_q.long_press_ms;
			REG_DOUBLE_PRESS: prdata = cfg_q.double_press_ms;
			REG_INVERT:       prdata = {{(DATA_W-1){1'b0}}, cfg_q.invert_polarity};
			REG_PAUSED:       prdata = {{(DATA_W-1){1'b0}}, cfg_q.paused};
			default:          prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

### design/bpc_core.sv
// Debounce and press classification state with its next-state logic.
`timescale 1ns / 1ps
`default_nettype none
module bpc_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bpc_pkg::cfg_t     cfg,
	input  wire logic              step,
	input  wire bpc_pkg::in_item_t item,
	output bpc_pkg::result_t       result
);
	import bpc_pkg::*;

	logic              started_q, started_d;
	logic              flicker_q, flicker_d;
	logic              steady_q, steady_d;
	logic              prior_q, prior_d;
	logic [TIME_W-1:0] last_change_q, last_change_d;
	logic [TIME_W-1:0] press_start_q, press_start_d;
	logic [TIME_W-1:0] last_release_q, last_release_d;
	logic [TIME_W-1:0] hold_q, hold_d;
	press_kind_t       kind_q, kind_d;
	logic              double_q, double_d;
	logic              held_q, held_d;
	logic              is_press, is_release, long_hit;

	always_comb begin
		started_d = started_q;
		flicker_d = flicker_q;
		steady_d = steady_q;
		prior_d = prior_q;
		last_change_d = last_change_q;
		press_start_d = press_start_q;
		last_release_d = last_release_q;
		hold_d = hold_q;
		kind_d = kind_q;
		double_d = double_q;
		held_d = held_q;
		is_press = 1'b0;
		is_release = 1'b0;
		long_hit = 1'b0;

		if (item.op == OP_START) begin
			prior_d = item.pin_level;
			steady_d = item.pin_level;
			flicker_d = item.pin_level;
			started_d = 1'b1;
		end else if (started_q && !cfg.paused) begin
			double_d = 1'b0;
			// promote to long using the hold time of the previous tick
			if (kind_q == KIND_NORMAL && hold_q >= cfg.long_press_ms) begin
				kind_d = KIND_LONG;
			end
			hold_d = held_q ? item.now_ms - press_start_q : '0;

			if (item.pin_level != flicker_q) begin
				last_change_d = item.now_ms;
				flicker_d = item.pin_level;
			end
			if (item.now_ms - last_change_d >= cfg.debounce_ms) begin
				prior_d = steady_q;
				steady_d = item.pin_level;
			end

			if (cfg.invert_polarity) begin
				is_press = !prior_d && steady_d;
				is_release = prior_d && !steady_d;
			end else begin
				is_press = prior_d && !steady_d;
				is_release = !prior_d && steady_d;
			end

			if (is_press) begin
				kind_d = KIND_NORMAL;
				press_start_d = item.now_ms;
				held_d = 1'b1;
			end
			if (is_release) begin
				held_d = 1'b0;
				double_d = (item.now_ms - last_release_q) < cfg.double_press_ms;
				last_release_d = item.now_ms;
			end
			long_hit = (kind_d == KIND_NORMAL) && (hold_d >= cfg.long_press_ms);
		end

		result.press_event = is_press;
		result.release_event = is_release;
		result.long_press_event = long_hit;
		result.double_press = double_d;
		result.hold_ms = hold_d;
		result.press_kind = kind_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			flicker_q <= 1'b0;
			steady_q <= 1'b0;
			prior_q <= 1'b0;
			last_change_q <= '0;
			press_start_q <= '0;
			last_release_q <= '0;
			hold_q <= '0;
			kind_q <= KIND_NONE;
			double_q <= 1'b0;
			held_q <= 1'b0;
		end else if (step) begin
			started_q <= started_d;
			flicker_q <= flicker_d;
			steady_q <= steady_d;
			prior_q <= prior_d;
			last_change_q <= last_change_d;
			press_start_q <= press_start_d;
			last_release_q <= last_release_d;
			hold_q <= hold_d;
			kind_q <= kind_d;
			double_q <= double_d;
			held_q <= held_d;
		end
	end

endmodule
`default_nettype wire

### design/button_press_classifier_unit.sv
// Top level of the button press classifier: stream channels, pipeline and config port.
//
// Usage
//   Input channel s_*: each item carries the raw pin level and a millisecond
//   timestamp in s_tdata, and the op in s_tuser (0 sample tick, 1 start that
//   seeds the debounce levels from the pin). Ticks before the first start,
//   or while paused is set, leave the state untouched.
//   Output channel m_*: exactly one result item per input item, in order,
//   with press, release, long-press and double-press flags, the hold time
//   and the last press kind.
//   Config port: APB-style, registers at byte addresses 0,4,8,12,16
//   (debounce, long press, double press, invert, paused). Write only while
//   no item is in flight; pready is tied high.
// Timing
//   An accepted item is captured in the input register, then moves through
//   the classifier logic into the result register once that register is
//   free or being emptied. Throughput is one item per cycle while m_tready
//   stays high, set by the state update (32-bit subtract-compares).
// Reset and stall
//   arst_n resets valid flags, core state and config to defaults, not the payloads.
//   When m_tready is low the result holds; the input register still takes
//   one more item, then s_tready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module button_press_classifier_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// s_tdata: [0] pin_level, [32:1] now_ms, [39:33] zero
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [bpc_pkg::IN_TDATA_W-1:0]  s_tdata,
	// s_tuser: [0] op
	input  wire logic                            s_tuser,
	// m_tdata: [0] press_event, [1] release_event, [2] long_press_event,
	//          [3] double_press, [35:4] hold_ms, [37:36] press_kind, [39:38] zero
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [bpc_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [bpc_pkg::ADDR_W-1:0]      paddr,
	input  wire logic [bpc_pkg::DATA_W-1:0]      pwdata,
	output logic      [bpc_pkg::DATA_W-1:0]      prdata,
	output logic                                 pready
);
	import bpc_pkg::*;

	localparam int unsigned RES_W = $bits(result_t);

	cfg_t     cfg;
	in_item_t item_s1;
	logic     valid_s1;
	result_t  res_comb;
	result_t  res_s2;
	logic     valid_s2;
	logic     advance;
	logic     in_take;

	bpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Advance the held item into the result register whenever that slot is
	// free or being emptied this cycle.
	assign advance = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_take = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Payload of the input register: capture only on accept.
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.op <= op_t'(s_tuser);
			item_s1.pin_level <= s_tdata[0];
			item_s1.now_ms <= s_tdata[TIME_W:1];
		end
	end

	bpc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.item   (item_s1),
		.result (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Hold the result while the receiver stalls.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = {{(OUT_TDATA_W-RES_W){1'b0}}, res_s2};

endmodule
`default_nettype wire

### design/bpc_checker.sv
// Port-level assertions for the button press classifier, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bpc_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [bpc_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import bpc_pkg::*;

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// One steady edge is either a press or a release, never both.
	a_edge_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("press and release in one item");

	// A press reports a normal kind.
	a_press_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[37:36] == KIND_NORMAL)
		else $error("press without normal kind");

	// A long press is flagged only while the kind is still normal.
	a_long_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[37:36] == KIND_NORMAL)
		else $error("long press flagged with wrong kind");

	// Padding bits stay zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:38] == '0)
		else $error("nonzero padding in result");

endmodule

bind button_press_classifier_unit bpc_checker u_bpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
